### rtl/rxq_pkg.sv
// Shared types, constants and helper functions for the xterm-256 quantiser.
// No dependencies; imported by every module under rtl/.
`default_nettype none

package rxq_pkg;

  // Per-stage advance enables of the pipeline, stage 1 nearest the input
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } rxq_adv_t;

  typedef logic [7:0]  chan_t;
  typedef logic [2:0]  step_t;
  typedef logic [4:0]  gray_k_t;
  typedef logic [17:0] dist_t;

  // Cube step thresholds; from 115 up the step is (c-35)/40 held to 5
  localparam int CUBE_T1    = 48;
  localparam int CUBE_T2    = 115;
  localparam int CUBE_OFS   = 35;
  localparam int CUBE_PITCH = 40;
  localparam int CUBE_T3    = CUBE_OFS + 3 * CUBE_PITCH;
  localparam int CUBE_T4    = CUBE_OFS + 4 * CUBE_PITCH;
  localparam int CUBE_T5    = CUBE_OFS + 5 * CUBE_PITCH;
  localparam int CUBE_BASE  = 55;
  localparam int CUBE_FIRST = 16;

  // Luminance weights and the reciprocal of the /1000
  localparam int LUMA_WR    = 299;
  localparam int LUMA_WG    = 587;
  localparam int LUMA_WB    = 114;
  localparam int LUMA_DIV   = 1000;
  localparam int LUMA_SHIFT = 28;
  localparam int LUMA_RECIP = ((1 << LUMA_SHIFT) + LUMA_DIV - 1) / LUMA_DIV;

  localparam int GRAY_OFS   = 3;
  localparam int GRAY_MAX   = 23;
  localparam int GRAY_BASE  = 8;
  localparam int GRAY_FIRST = 232;
  // x/10 == (x*205)>>11 for any 8-bit x
  localparam int DIV10_MUL  = 205;
  localparam int DIV10_SH   = 11;

  function automatic step_t cube_step(input chan_t c);
    step_t s;
    if (c < chan_t'(CUBE_T1))      s = 3'd0;
    else if (c < chan_t'(CUBE_T2)) s = 3'd1;
    else if (c < chan_t'(CUBE_T3)) s = 3'd2;
    else if (c < chan_t'(CUBE_T4)) s = 3'd3;
    else if (c < chan_t'(CUBE_T5)) s = 3'd4;
    else                           s = 3'd5;
    return s;
  endfunction

  function automatic chan_t cube_level(input step_t s);
    chan_t l;
    if (s == 3'd0) l = 8'd0;
    else           l = chan_t'(CUBE_BASE + CUBE_PITCH * int'(s));
    return l;
  endfunction

  function automatic chan_t abs_diff(input chan_t a, input chan_t b);
    chan_t d;
    if (a > b) d = a - b;
    else       d = b - a;
    return d;
  endfunction

  function automatic dist_t sq_sum3(input chan_t d0, input chan_t d1, input chan_t d2);
    logic [15:0] q0, q1, q2;
    q0 = d0 * d0;
    q1 = d1 * d1;
    q2 = d2 * d2;
    return dist_t'(q0) + dist_t'(q1) + dist_t'(q2);
  endfunction

  function automatic chan_t cube_entry(input step_t rs, input step_t gs, input step_t bs);
    return chan_t'(CUBE_FIRST + 36 * int'(rs) + 6 * int'(gs) + int'(bs));
  endfunction

  // Gray ramp entry from an 8-bit luminance, held to 0..23
  function automatic gray_k_t gray_step(input chan_t lum);
    chan_t       x;
    logic [15:0] p;
    gray_k_t     k;
    if (lum < chan_t'(GRAY_OFS)) x = 8'd0;
    else                         x = lum - chan_t'(GRAY_OFS);
    p = x * 8'(DIV10_MUL);
    k = p[DIV10_SH +: 5];
    if (k > gray_k_t'(GRAY_MAX)) k = gray_k_t'(GRAY_MAX);
    return k;
  endfunction

  function automatic chan_t ramp_level(input gray_k_t k);
    return chan_t'(GRAY_BASE + 10 * int'(k));
  endfunction

endpackage

`default_nettype wire

### rtl/rxq_cube.sv
// Colour-cube candidate: per-channel step, palette index and squared distance.
// Two register stages; depends on rxq_pkg.
`default_nettype none

module rxq_cube (
  input  wire logic              clk,
  input  wire rxq_pkg::rxq_adv_t adv,
  input  wire rxq_pkg::chan_t    red,
  input  wire rxq_pkg::chan_t    green,
  input  wire rxq_pkg::chan_t    blue,
  output rxq_pkg::chan_t         cube_idx,
  output rxq_pkg::dist_t         cube_dist
);
  import rxq_pkg::*;

  step_t rs_next, gs_next, bs_next;
  step_t rs, gs, bs;
  chan_t dr, dg, db;

  always_comb begin
    rs_next = cube_step(red);
    gs_next = cube_step(green);
    bs_next = cube_step(blue);
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      rs <= rs_next;
      gs <= gs_next;
      bs <= bs_next;
      dr <= abs_diff(red, cube_level(rs_next));
      dg <= abs_diff(green, cube_level(gs_next));
      db <= abs_diff(blue, cube_level(bs_next));
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      cube_idx  <= cube_entry(rs, gs, bs);
      cube_dist <= sq_sum3(dr, dg, db);
    end
  end

endmodule

`default_nettype wire

### rtl/rxq_luma.sv
// Gray-ramp candidate: weighted luminance, reciprocal divide, ramp step and distance.
// Four register stages, distance left combinational after the last; depends on rxq_pkg.
`default_nettype none

module rxq_luma (
  input  wire logic              clk,
  input  wire rxq_pkg::rxq_adv_t adv,
  input  wire rxq_pkg::chan_t    red,
  input  wire rxq_pkg::chan_t    green,
  input  wire rxq_pkg::chan_t    blue,
  output rxq_pkg::gray_k_t       gray_k,
  output rxq_pkg::dist_t         gray_dist
);
  import rxq_pkg::*;

  localparam int RecipW = $clog2(LUMA_RECIP + 1);
  localparam int SumW   = 18;

  logic [16:0]          pr;
  logic [17:0]          pg;
  logic [14:0]          pb;
  chan_t                r1, g1, b1, r2, g2, b2, r3, g3, b3;
  logic [SumW-1:0]      wsum;
  logic [SumW+RecipW-1:0] prod;
  chan_t                lum;
  chan_t                dr, dg, db;
  gray_k_t              k_next;

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      pr <= 17'(red * 9'(LUMA_WR));
      pg <= 18'(green * 10'(LUMA_WG));
      pb <= 15'(blue * 7'(LUMA_WB));
      r1 <= red;
      g1 <= green;
      b1 <= blue;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      wsum <= SumW'(pr) + SumW'(pg) + SumW'(pb);
      r2   <= r1;
      g2   <= g1;
      b2   <= b1;
    end
  end

  // divide by 1000 through the rounded-up reciprocal, exact below 2^18
  assign prod = wsum * RecipW'(LUMA_RECIP);

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      lum <= prod[LUMA_SHIFT +: 8];
      r3  <= r2;
      g3  <= g2;
      b3  <= b2;
    end
  end

  assign k_next = gray_step(lum);

  always_ff @(posedge clk) begin
    if (adv.s4) begin
      gray_k <= k_next;
      dr     <= abs_diff(r3, ramp_level(k_next));
      dg     <= abs_diff(g3, ramp_level(k_next));
      db     <= abs_diff(b3, ramp_level(k_next));
    end
  end

  assign gray_dist = sq_sum3(dr, dg, db);

endmodule

`default_nettype wire

### rtl/rgb_to_xterm256_quantizer.sv
// RGB pixel to xterm-256 palette index, five-stage pipeline.
// A request moves through stages 1 to 5; index_valid is the stage 5 valid bit.
// Throughput: one request per cycle unless stalled; the 18x19 luminance reciprocal
// multiply and the three-square distance sums each sit in a stage of their own.
// Reset clears the stage valid bits only; a stalled output backs up stage by stage.
// Depends on rxq_pkg, rxq_cube and rxq_luma.
`default_nettype none

module rgb_to_xterm256_quantizer (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           pixel_valid,
  output logic                pixel_ready,
  input  wire rxq_pkg::chan_t red,
  input  wire rxq_pkg::chan_t green,
  input  wire rxq_pkg::chan_t blue,
  output logic                index_valid,
  input  wire logic           index_ready,
  output rxq_pkg::chan_t      palette_index
);
  import rxq_pkg::*;

  rxq_adv_t adv;
  logic     v1, v2, v3, v4, v5;
  chan_t    cube_idx, idx3, idx4;
  dist_t    cube_dist, dist3, dist4;
  gray_k_t  gray_k;
  dist_t    gray_dist;
  chan_t    palette_index_next;

  // a stage moves on when it is empty or its successor moves on
  always_comb begin
    adv.s5 = !v5 || index_ready;
    adv.s4 = !v4 || adv.s5;
    adv.s3 = !v3 || adv.s4;
    adv.s2 = !v2 || adv.s3;
    adv.s1 = !v1 || adv.s2;
  end

  assign pixel_ready = adv.s1;
  assign index_valid = v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (adv.s1) v1 <= pixel_valid;
      if (adv.s2) v2 <= v1;
      if (adv.s3) v3 <= v2;
      if (adv.s4) v4 <= v3;
      if (adv.s5) v5 <= v4;
    end
  end

  rxq_cube u_cube (
    .clk       (clk),
    .adv       (adv),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .cube_idx  (cube_idx),
    .cube_dist (cube_dist)
  );

  rxq_luma u_luma (
    .clk       (clk),
    .adv       (adv),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .gray_k    (gray_k),
    .gray_dist (gray_dist)
  );

  // hold the cube candidate level with the gray one
  always_ff @(posedge clk) begin
    if (adv.s3) begin
      idx3  <= cube_idx;
      dist3 <= cube_dist;
    end
    if (adv.s4) begin
      idx4  <= idx3;
      dist4 <= dist3;
    end
  end

  // gray only when strictly nearer; ties keep the cube entry
  always_comb begin
    if (gray_dist < dist4) palette_index_next = chan_t'(GRAY_FIRST + int'(gray_k));
    else                   palette_index_next = idx4;
  end

  always_ff @(posedge clk) begin
    if (adv.s5) palette_index <= palette_index_next;
  end

endmodule

`default_nettype wire
